// ===== src/page_pool_allocator_top_assert.svh =====
// Assertion macros for the page pool allocator
`ifndef PAGE_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define PAGE_POOL_ALLOCATOR_TOP_ASSERT_SVH

`define PPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page pool allocator check failed");

`define PPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page pool allocator check failed");

`endif

// ===== src/ppa_pkg.sv =====
// Types and constants shared by the page pool allocator modules
`default_nettype none
package ppa_pkg;

  localparam int PAGE_COUNT  = 1024;
  localparam int MAX_REQUEST = 64;
  localparam int ID_W        = 10;
  localparam int SZ_W        = 11;
  localparam int CNT_W       = 7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFREE   = 3'd1;
  localparam logic [2:0] ST_NORUN    = 3'd2;
  localparam logic [2:0] ST_BADID    = 3'd3;
  localparam logic [2:0] ST_NOTALLOC = 3'd4;
  localparam logic [2:0] ST_ZERO     = 3'd5;

  typedef enum logic [2:0] {
    OP_GET    = 3'd0,
    OP_BATCH  = 3'd1,
    OP_PUT    = 3'd2,
    OP_FREE   = 3'd3,
    OP_CONTIG = 3'd4,
    OP_SCAT   = 3'd5,
    OP_NONE   = 3'd6
  } ppa_op_t;

  typedef struct packed {
    ppa_op_t            op;
    logic [ID_W-1:0]    page;
    logic [CNT_W-1:0]   count;
    logic               err;
    logic [2:0]         err_status;
  } ppa_cmd_t;

  typedef struct packed {
    logic               clearing;
    logic [SZ_W-1:0]    pool_pages;
  } ppa_stat_t;

endpackage
`default_nettype wire

// ===== src/ppa_ram.sv =====
// Generic simple dual-port RAM with registered read
`default_nettype none
module ppa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/ppa_queue.sv =====
// Two-entry command queue between front and back
`default_nettype none
module ppa_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ppa_pkg::ppa_cmd_t din,
  output logic                   full,
  input  wire logic              pop,
  output ppa_pkg::ppa_cmd_t      dout,
  output logic                   valid
);
  import ppa_pkg::*;

  ppa_cmd_t   store [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign dout  = store[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wp] <= din;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      if (push && !pop)      cnt <= cnt + 2'd1;
      else if (!push && pop) cnt <= cnt - 2'd1;
    end
  end
endmodule
`default_nettype wire

// ===== src/ppa_front.sv =====
// Request intake: accepts, decodes and pre-checks requests, queues them
`default_nettype none
module ppa_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [2:0]                func,
  input  wire logic [ppa_pkg::ID_W-1:0]  page_number,
  input  wire logic [ppa_pkg::CNT_W-1:0] request_count,
  input  wire ppa_pkg::ppa_stat_t        stat,
  output ppa_pkg::ppa_cmd_t              cmd,
  output logic                           cmd_valid,
  input  wire logic                      cmd_pop
);
  import ppa_pkg::*;

  ppa_cmd_t cmd_in;
  logic     full;
  logic     push;

  assign busy = full | stat.clearing;
  assign push = start & ~busy;

  always_comb begin
    cmd_in.op         = (func > OP_SCAT) ? OP_NONE : ppa_op_t'(func);
    cmd_in.page       = '0;
    cmd_in.count      = request_count;
    cmd_in.err        = 1'b0;
    cmd_in.err_status = ST_OK;
    if (cmd_in.op inside {OP_PUT, OP_FREE}) begin
      cmd_in.page = page_number;
      if ({1'b0, page_number} >= stat.pool_pages) begin
        cmd_in.err        = 1'b1;
        cmd_in.err_status = ST_BADID;
      end
    end
    if (cmd_in.op inside {OP_BATCH, OP_CONTIG, OP_SCAT}) begin
      if (request_count == '0) begin
        cmd_in.err        = 1'b1;
        cmd_in.err_status = ST_ZERO;
      end else if (cmd_in.op != OP_CONTIG &&
                   request_count > CNT_W'(MAX_REQUEST)) begin
        cmd_in.err        = 1'b1;
        cmd_in.err_status = ST_NOFREE;
      end
    end
  end

  ppa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd),
    .valid (cmd_valid)
  );
endmodule
`default_nettype wire

// ===== src/ppa_back.sv =====
// Request engine: free deque and bitmap memories, scans and compaction
`default_nettype none
module ppa_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [ppa_pkg::SZ_W-1:0]  cfg_data,
  input  wire ppa_pkg::ppa_cmd_t         cmd,
  input  wire logic                      cmd_valid,
  output logic                           cmd_pop,
  output ppa_pkg::ppa_stat_t             stat,
  output logic                           result_strobe,
  output logic [ppa_pkg::ID_W-1:0]       result_page,
  output logic [2:0]                     status,
  output logic                           last,
  output logic [ppa_pkg::SZ_W-1:0]       free_count
);
  import ppa_pkg::*;

  typedef enum logic [11:0] {
    S_CLR      = 12'b000000000001,
    S_IDLE     = 12'b000000000010,
    S_GET_RD   = 12'b000000000100,
    S_GET_WR   = 12'b000000001000,
    S_PUT_RD   = 12'b000000010000,
    S_PUT_WR   = 12'b000000100000,
    S_SCAN_RD  = 12'b000001000000,
    S_SCAN_CHK = 12'b000010000000,
    S_MARK     = 12'b000100000000,
    S_CMP_RD   = 12'b001000000000,
    S_CMP_BM   = 12'b010000000000,
    S_CMP_WR   = 12'b100000000000
  } state_t;

  state_t            state;
  logic [SZ_W-1:0]   pool;
  logic [SZ_W-1:0]   clr_idx;
  logic [ID_W-1:0]   head;
  logic [SZ_W-1:0]   size;
  logic [SZ_W-1:0]   fc;
  ppa_op_t           op;
  logic [ID_W-1:0]   pg;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  run;
  logic [ID_W-1:0]   sid;
  logic [ID_W-1:0]   start_pg;
  logic [SZ_W-1:0]   ci;
  logic [SZ_W-1:0]   cj;
  logic [ID_W-1:0]   cid;
  logic [SZ_W-1:0]   cfg_clamped;
  logic              k_last;
  logic              run_hit;

  logic              dq_we;
  logic [ID_W-1:0]   dq_waddr;
  logic [ID_W-1:0]   dq_wdata;
  logic [ID_W-1:0]   dq_raddr;
  logic [ID_W-1:0]   dq_rdata;
  logic              bm_we;
  logic [ID_W-1:0]   bm_waddr;
  logic              bm_wdata;
  logic [ID_W-1:0]   bm_raddr;
  logic              bm_rdata;

  assign stat            = '{clearing: (state == S_CLR), pool_pages: pool};
  assign cmd_pop         = (state == S_IDLE) && cmd_valid;
  assign k_last          = ({1'b0, k} + 8'd1) == {1'b0, cnt};
  assign run_hit         = ({1'b0, run} + 8'd1) == {1'b0, cnt};

  always_comb begin
    if (cfg_data == '0)                      cfg_clamped = SZ_W'(1);
    else if (cfg_data > SZ_W'(PAGE_COUNT))   cfg_clamped = SZ_W'(PAGE_COUNT);
    else                                     cfg_clamped = cfg_data;
  end

  ppa_ram #(.WIDTH(ID_W), .DEPTH(PAGE_COUNT)) u_deque (
    .clk (clk), .we (dq_we), .waddr (dq_waddr), .wdata (dq_wdata),
    .raddr (dq_raddr), .rdata (dq_rdata)
  );

  ppa_ram #(.WIDTH(1), .DEPTH(PAGE_COUNT)) u_bitmap (
    .clk (clk), .we (bm_we), .waddr (bm_waddr), .wdata (bm_wdata),
    .raddr (bm_raddr), .rdata (bm_rdata)
  );

  always_comb begin
    dq_we    = 1'b0;
    dq_waddr = '0;
    dq_wdata = '0;
    dq_raddr = '0;
    bm_we    = 1'b0;
    bm_waddr = '0;
    bm_wdata = 1'b0;
    bm_raddr = '0;
    case (state)
      S_CLR: begin
        dq_we    = 1'b1;
        dq_waddr = clr_idx[ID_W-1:0];
        dq_wdata = clr_idx[ID_W-1:0];
        bm_we    = 1'b1;
        bm_waddr = clr_idx[ID_W-1:0];
      end
      S_GET_RD: dq_raddr = head;
      S_GET_WR: begin
        bm_we    = 1'b1;
        bm_waddr = dq_rdata;
        bm_wdata = 1'b1;
      end
      S_PUT_RD: bm_raddr = pg;
      S_PUT_WR: begin
        if (bm_rdata) begin
          bm_we    = 1'b1;
          bm_waddr = pg;
          dq_we    = 1'b1;
          dq_wdata = pg;
          dq_waddr = (op == OP_PUT) ? head - ID_W'(1) : head + size[ID_W-1:0];
        end
      end
      S_SCAN_RD: bm_raddr = sid;
      S_SCAN_CHK: begin
        if (op == OP_SCAT && !bm_rdata) begin
          bm_we    = 1'b1;
          bm_waddr = sid;
          bm_wdata = 1'b1;
        end
      end
      S_MARK: begin
        bm_we    = 1'b1;
        bm_waddr = start_pg + ID_W'(k);
        bm_wdata = 1'b1;
      end
      S_CMP_RD: dq_raddr = head + ci[ID_W-1:0];
      S_CMP_BM: bm_raddr = dq_rdata;
      S_CMP_WR: begin
        if (!bm_rdata) begin
          dq_we    = 1'b1;
          dq_waddr = head + cj[ID_W-1:0];
          dq_wdata = cid;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    result_strobe <= 1'b0;
    if (rst) begin
      state   <= S_CLR;
      pool    <= SZ_W'(PAGE_COUNT);
      clr_idx <= '0;
      head    <= '0;
      size    <= '0;
    end else if (cfg_we) begin
      state   <= S_CLR;
      pool    <= cfg_clamped;
      clr_idx <= '0;
    end else begin
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + SZ_W'(1);
          if (clr_idx == SZ_W'(PAGE_COUNT - 1)) begin
            head  <= '0;
            size  <= pool;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            op  <= cmd.op;
            pg  <= cmd.page;
            cnt <= cmd.count;
            k   <= '0;
            run <= '0;
            sid <= pool[ID_W-1:0] - ID_W'(1);
            fc  <= size - SZ_W'(cmd.count);
            if (cmd.err) begin
              result_strobe <= 1'b1;
              result_page   <= cmd.page;
              status        <= cmd.err_status;
              last          <= 1'b1;
              free_count    <= size;
            end else begin
              case (cmd.op)
                OP_GET: begin
                  cnt <= CNT_W'(1);
                  fc  <= size - SZ_W'(1);
                  if (size == '0) begin
                    result_strobe <= 1'b1;
                    result_page   <= '0;
                    status        <= ST_NOFREE;
                    last          <= 1'b1;
                    free_count    <= size;
                  end else begin
                    state <= S_GET_RD;
                  end
                end
                OP_BATCH, OP_CONTIG, OP_SCAT: begin
                  if (SZ_W'(cmd.count) > size) begin
                    result_strobe <= 1'b1;
                    result_page   <= '0;
                    status        <= ST_NOFREE;
                    last          <= 1'b1;
                    free_count    <= size;
                  end else if (cmd.op == OP_BATCH) begin
                    state <= S_GET_RD;
                  end else begin
                    state <= S_SCAN_RD;
                  end
                end
                OP_PUT, OP_FREE: state <= S_PUT_RD;
                default: begin
                  result_strobe <= 1'b1;
                  result_page   <= '0;
                  status        <= ST_OK;
                  last          <= 1'b1;
                  free_count    <= size;
                end
              endcase
            end
          end
        end
        S_GET_RD: state <= S_GET_WR;
        S_GET_WR: begin
          result_strobe <= 1'b1;
          result_page   <= dq_rdata;
          status        <= ST_OK;
          last          <= k_last;
          free_count    <= fc;
          head          <= head + ID_W'(1);
          size          <= size - SZ_W'(1);
          k             <= k + CNT_W'(1);
          state         <= k_last ? S_IDLE : S_GET_RD;
        end
        S_PUT_RD: state <= S_PUT_WR;
        S_PUT_WR: begin
          result_strobe <= 1'b1;
          result_page   <= pg;
          last          <= 1'b1;
          state         <= S_IDLE;
          if (bm_rdata) begin
            status     <= ST_OK;
            free_count <= size + SZ_W'(1);
            size       <= size + SZ_W'(1);
            if (op == OP_PUT) head <= head - ID_W'(1);
          end else begin
            status     <= ST_NOTALLOC;
            free_count <= size;
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          state <= S_SCAN_RD;
          sid   <= sid - ID_W'(1);
          if (op == OP_CONTIG) begin
            if (!bm_rdata && run_hit) begin
              start_pg <= sid;
              state    <= S_MARK;
            end else begin
              run <= bm_rdata ? '0 : run + CNT_W'(1);
              if (sid == '0) begin
                result_strobe <= 1'b1;
                result_page   <= '0;
                status        <= ST_NORUN;
                last          <= 1'b1;
                free_count    <= size;
                state         <= S_IDLE;
              end
            end
          end else begin
            if (!bm_rdata) begin
              result_strobe <= 1'b1;
              result_page   <= sid;
              status        <= ST_OK;
              last          <= k_last;
              free_count    <= fc;
              k             <= k + CNT_W'(1);
            end
            if ((!bm_rdata && k_last) || sid == '0) begin
              ci    <= '0;
              cj    <= '0;
              state <= S_CMP_RD;
            end
          end
        end
        S_MARK: begin
          k <= k + CNT_W'(1);
          if (k_last) begin
            ci    <= '0;
            cj    <= '0;
            state <= S_CMP_RD;
          end
        end
        S_CMP_RD: state <= S_CMP_BM;
        S_CMP_BM: begin
          cid   <= dq_rdata;
          state <= S_CMP_WR;
        end
        S_CMP_WR: begin
          ci    <= ci + SZ_W'(1);
          state <= S_CMP_RD;
          if (!bm_rdata) cj <= cj + SZ_W'(1);
          if (ci + SZ_W'(1) == size) begin
            size  <= bm_rdata ? cj : cj + SZ_W'(1);
            state <= S_IDLE;
            if (op == OP_CONTIG) begin
              result_strobe <= 1'b1;
              result_page   <= start_pg;
              status        <= ST_OK;
              last          <= 1'b1;
              free_count    <= bm_rdata ? cj : cj + SZ_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/page_pool_allocator_top.sv =====
// Top level of the page pool allocator
//
// Requests enter on start/func/page_number/request_count and are taken on a
// clock edge with start high and busy low. Up to two requests queue ahead of
// the engine. Each result is shown for one cycle with result_strobe high;
// last marks the final result of a request. The receiver cannot stall.
// A get reads the free deque head, then marks that page in the bitmap; a
// batch get repeats this per page. Put and free read the page's bitmap bit,
// then return an allocated page to the deque head or tail. The right-side
// requests scan the bitmap one page id at a time from the top, then compact
// the free deque entry by entry. The deque and bitmap memories have one
// read and one write port each. pool_pages is written through
// cfg_valid/cfg_ready; the user must write it only while idle, and the
// block does not enforce it. After reset and every pool_pages write, busy
// is high while a clearing pass refills the deque and clears the bitmap.
`default_nettype none
module page_pool_allocator_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [2:0]                func,
  input  wire logic [ppa_pkg::ID_W-1:0]  page_number,
  input  wire logic [ppa_pkg::CNT_W-1:0] request_count,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [ppa_pkg::SZ_W-1:0]  pool_pages,
  output logic                           result_strobe,
  output logic [ppa_pkg::ID_W-1:0]       result_page,
  output logic [2:0]                     status,
  output logic                           last,
  output logic [ppa_pkg::SZ_W-1:0]       free_count
);
  import ppa_pkg::*;

  ppa_stat_t stat;
  ppa_cmd_t  cmd;
  logic      cmd_valid;
  logic      cmd_pop;

  assign cfg_ready = 1'b1;

  ppa_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .page_number   (page_number),
    .request_count (request_count),
    .stat          (stat),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop)
  );

  ppa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_data      (pool_pages),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop),
    .stat          (stat),
    .result_strobe (result_strobe),
    .result_page   (result_page),
    .status        (status),
    .last          (last),
    .free_count    (free_count)
  );

`include "page_pool_allocator_top_assert.svh"

  `PPA_ASSERT_IMP(a_no_result_clr, result_strobe, !stat.clearing)
  `PPA_ASSERT_IMP(a_fc_bound, result_strobe, free_count <= stat.pool_pages)
  `PPA_ASSERT_IMP(a_busy_clr, stat.clearing, busy)
  `PPA_ASSERT_NXT(a_cfg_clears, cfg_valid && cfg_ready, stat.clearing)

endmodule
`default_nettype wire

// ===== tb/sv/tb_page_pool_allocator_top.sv =====
// Self-checking testbench for page_pool_allocator_top: directed table plus random requests
`timescale 1ns / 100ps
module tb_page_pool_allocator_top;
  import ppa_pkg::*;

  localparam logic [2:0] OP_SPARE = 3'd7;
  localparam int WATCHDOG = 200000;
  localparam int RAND_ITEMS = 420;

  typedef struct packed {
    logic [ID_W-1:0] page;
    logic [2:0]      st;
    logic            lst;
    logic [SZ_W-1:0] free;
  } grant_t;

  typedef struct {
    bit              is_cfg;
    logic [SZ_W-1:0] cfg;
    logic [2:0]      op;
    logic [ID_W-1:0] pg;
    logic [CNT_W-1:0] cnt;
    bit              typed;
    logic [ID_W-1:0] xpage;
    logic [2:0]      xst;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [2:0] func = '0;
  logic [ID_W-1:0] page_number = '0;
  logic [CNT_W-1:0] request_count = '0;
  logic cfg_valid = 0;
  logic [SZ_W-1:0] pool_pages = SZ_W'(PAGE_COUNT);
  logic busy, cfg_ready, result_strobe, last;
  logic [ID_W-1:0] result_page;
  logic [2:0] status;
  logic [SZ_W-1:0] free_count;

  page_pool_allocator_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .page_number(page_number), .request_count(request_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .pool_pages(pool_pages),
    .result_strobe(result_strobe), .result_page(result_page), .status(status),
    .last(last), .free_count(free_count)
  );

  always #6 clk = ~clk;

  // shadow of the pool
  bit              page_taken [0:PAGE_COUNT-1];
  logic [ID_W-1:0] free_ring [0:PAGE_COUNT-1];
  int              ring_head, ring_size, pool_size;
  grant_t          grants_q[$];
  int              errors = 0;
  bit              idle_en = 1;
  row_t            dir_rows[$];

  function automatic void pool_init(int n);
    for (int i = 0; i < PAGE_COUNT; i++) begin
      page_taken[i] = 0;
      free_ring[i] = (i < n) ? ID_W'(i) : '0;
    end
    ring_head = 0;
    ring_size = n;
  endfunction

  function automatic void pool_set(logic [SZ_W-1:0] v);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > PAGE_COUNT) n = PAGE_COUNT;
    pool_size = n;
    pool_init(n);
  endfunction

  function automatic logic [ID_W-1:0] ring_pop();
    logic [ID_W-1:0] id;
    id = free_ring[ring_head];
    ring_head = (ring_head + 1) % PAGE_COUNT;
    ring_size--;
    return id;
  endfunction

  function automatic void ring_compact();
    int j;
    j = 0;
    for (int i = 0; i < ring_size; i++) begin
      logic [ID_W-1:0] id;
      id = free_ring[(ring_head + i) % PAGE_COUNT];
      if (!page_taken[id]) begin
        free_ring[(ring_head + j) % PAGE_COUNT] = id;
        j++;
      end
    end
    ring_size = j;
  endfunction

  function automatic void put_grant(logic [ID_W-1:0] page, logic [2:0] st, logic lst);
    grants_q.insert(grants_q.size(), '{page, st, lst, '0});
  endfunction

  // works out the grants one request causes and queues them
  function automatic void allocate_predict(logic [2:0] op, logic [ID_W-1:0] pg,
                                           logic [CNT_W-1:0] cnt);
    int n, run, first, qn;
    bit found;
    logic [ID_W-1:0] picks[$];
    n = int'(cnt);
    qn = grants_q.size();
    case (op)
      OP_GET: begin
        if (ring_size == 0) put_grant('0, ST_NOFREE, 1'b1);
        else begin
          logic [ID_W-1:0] id;
          id = ring_pop();
          page_taken[id] = 1;
          put_grant(id, ST_OK, 1'b1);
        end
      end
      OP_BATCH: begin
        if (n == 0) put_grant('0, ST_ZERO, 1'b1);
        else if (n > MAX_REQUEST || n > ring_size) put_grant('0, ST_NOFREE, 1'b1);
        else for (int i = 0; i < n; i++) begin
          logic [ID_W-1:0] id;
          id = ring_pop();
          page_taken[id] = 1;
          put_grant(id, ST_OK, (i == n - 1));
        end
      end
      OP_PUT, OP_FREE: begin
        if (int'(pg) >= pool_size) put_grant(pg, ST_BADID, 1'b1);
        else if (!page_taken[pg] || ring_size >= PAGE_COUNT)
          put_grant(pg, ST_NOTALLOC, 1'b1);
        else begin
          page_taken[pg] = 0;
          if (op == OP_PUT) begin
            ring_head = (ring_head + PAGE_COUNT - 1) % PAGE_COUNT;
            free_ring[ring_head] = pg;
          end else
            free_ring[(ring_head + ring_size) % PAGE_COUNT] = pg;
          ring_size++;
          put_grant(pg, ST_OK, 1'b1);
        end
      end
      OP_CONTIG: begin
        run = 0; first = 0; found = 0;
        if (n == 0) put_grant('0, ST_ZERO, 1'b1);
        else if (n > ring_size) put_grant('0, ST_NOFREE, 1'b1);
        else begin
          for (int i = pool_size - 1; i >= 0 && !found; i--) begin
            if (!page_taken[i]) begin
              run++;
              if (run == n) begin first = i; found = 1; end
            end else run = 0;
          end
          if (!found) put_grant('0, ST_NORUN, 1'b1);
          else begin
            for (int i = 0; i < n; i++) page_taken[first + i] = 1;
            ring_compact();
            put_grant(ID_W'(first), ST_OK, 1'b1);
          end
        end
      end
      OP_SCAT: begin
        if (n == 0) put_grant('0, ST_ZERO, 1'b1);
        else if (n > MAX_REQUEST || n > ring_size) put_grant('0, ST_NOFREE, 1'b1);
        else begin
          for (int i = pool_size - 1; i >= 0 && picks.size() < n; i--)
            if (!page_taken[i]) picks.insert(picks.size(), ID_W'(i));
          if (picks.size() < n) put_grant('0, ST_NOFREE, 1'b1);
          else begin
            foreach (picks[i]) begin
              page_taken[picks[i]] = 1;
              put_grant(picks[i], ST_OK, (i == n - 1));
            end
            ring_compact();
          end
        end
      end
      default: put_grant('0, ST_OK, 1'b1);
    endcase
    for (int i = qn; i < grants_q.size(); i++)
      grants_q[i].free = SZ_W'(ring_size);
  endfunction

  task automatic wait_drained();
    while (grants_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_pool(logic [SZ_W-1:0] v);
    wait_drained();
    cfg_valid <= 1;
    pool_pages <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    pool_set(v);
  endtask

  // one request transaction; typed values override the predicted first grant
  task automatic issue(logic [2:0] op, logic [ID_W-1:0] pg, logic [CNT_W-1:0] cnt,
                       bit typed = 0, logic [ID_W-1:0] xpage = '0, logic [2:0] xst = '0);
    int qn;
    if (idle_en && $urandom_range(0, 99) < 33) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    func <= op;
    page_number <= pg;
    request_count <= cnt;
    do @(posedge clk); while (busy);
    qn = grants_q.size();
    allocate_predict(op, pg, cnt);
    if (typed) begin
      grants_q[qn].page = xpage;
      grants_q[qn].st = xst;
    end
  endtask

  task automatic idle_start();
    start <= 0;
    @(posedge clk);
  endtask

  function automatic row_t mk(logic [2:0] op, int pg, int cnt, bit typed = 0,
                              int xpage = 0, logic [2:0] xst = ST_OK);
    row_t r;
    r = '{0, '0, op, ID_W'(pg), CNT_W'(cnt), typed, ID_W'(xpage), xst};
    return r;
  endfunction

  function automatic row_t mk_cfg(int v);
    row_t r;
    r = '{1, SZ_W'(v), OP_GET, '0, '0, 0, '0, ST_OK};
    return r;
  endfunction

  function automatic void add_row(row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic logic [ID_W-1:0] pick_page();
    int s;
    if ($urandom_range(0, 3) == 0) return ID_W'($urandom_range(0, PAGE_COUNT - 1));
    s = $urandom_range(0, pool_size - 1);
    if ($urandom_range(0, 9) < 7)
      for (int i = 0; i < pool_size; i++)
        if (page_taken[(s + i) % pool_size]) return ID_W'((s + i) % pool_size);
    return ID_W'(s);
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 14) return CNT_W'($urandom_range(65, 127));
    if (r < 20) return CNT_W'(MAX_REQUEST);
    return CNT_W'($urandom_range(1, 8));
  endfunction

  // result check
  always @(posedge clk) begin
    grant_t got, want;
    if (!rst && result_strobe) begin
      got = '{result_page, status, last, free_count};
      if (grants_q.size() == 0) begin
        $display("%0t unexpected result page %0d status %0d last %0d free %0d",
                 $time, got.page, got.st, got.lst, got.free);
        errors++;
      end else begin
        want = grants_q[0];
        grants_q.delete(0);
        if (got !== want) begin
          $display("%0t mismatch exp page %0d status %0d last %0d free %0d", $time,
                   want.page, want.st, want.lst, want.free);
          $display("%0t          got page %0d status %0d last %0d free %0d", $time,
                   got.page, got.st, got.lst, got.free);
          errors++;
        end
      end
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int pools[] = '{5, 1024, 2, 37, 3, 1024, 12, 1};
    pool_set(SZ_W'(PAGE_COUNT));
    repeat (10) @(posedge clk);
    rst <= 0;

    add_row(mk(OP_GET, 0, 0, 1, 0, ST_OK));
    add_row(mk(OP_PUT, 1023, 0, 1, 1023, ST_NOTALLOC));
    add_row(mk(OP_FREE, 5, 0, 1, 5, ST_NOTALLOC));
    add_row(mk(OP_PUT, 0, 0, 1, 0, ST_OK));
    add_row(mk(OP_BATCH, 0, 0, 1, 0, ST_ZERO));
    add_row(mk(OP_BATCH, 0, 65, 1, 0, ST_NOFREE));
    add_row(mk(OP_BATCH, 0, 64));
    add_row(mk(OP_SCAT, 0, 127, 1, 0, ST_NOFREE));
    add_row(mk(OP_SCAT, 0, 0, 1, 0, ST_ZERO));
    add_row(mk(OP_CONTIG, 0, 0, 1, 0, ST_ZERO));
    add_row(mk(OP_CONTIG, 0, 127));
    add_row(mk(OP_SCAT, 0, 64));
    add_row(mk(OP_FREE, 3, 0));
    add_row(mk(OP_PUT, 1023, 0));
    add_row(mk(OP_NONE, 1023, 127, 1, 0, ST_OK));
    add_row(mk(OP_SPARE, 682, 85, 1, 0, ST_OK));
    add_row(mk_cfg(0));
    add_row(mk(OP_GET, 0, 0, 1, 0, ST_OK));
    add_row(mk(OP_GET, 0, 0, 1, 0, ST_NOFREE));
    add_row(mk(OP_PUT, 1, 0, 1, 1, ST_BADID));
    add_row(mk(OP_PUT, 0, 0, 1, 0, ST_OK));
    add_row(mk(OP_CONTIG, 0, 2, 1, 0, ST_NOFREE));
    add_row(mk_cfg(4));
    add_row(mk(OP_BATCH, 0, 4));
    add_row(mk(OP_PUT, 1, 0));
    add_row(mk(OP_PUT, 3, 0));
    add_row(mk(OP_CONTIG, 0, 2, 1, 0, ST_NORUN));
    add_row(mk_cfg(2047));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        idle_start();
        write_pool(dir_rows[i].cfg);
      end else
        issue(dir_rows[i].op, dir_rows[i].pg, dir_rows[i].cnt, dir_rows[i].typed,
              dir_rows[i].xpage, dir_rows[i].xst);
    end

    foreach (pools[p]) begin
      idle_start();
      write_pool(SZ_W'(pools[p]));
      idle_en = (p != 2);
      for (int k = 0; k < RAND_ITEMS / pools.size(); k++) begin
        int f;
        f = $urandom_range(0, 39);
        if (k == 25 && p == 4) begin
          idle_start();
          wait_drained();
        end
        issue(f == 39 ? OP_SPARE : f == 38 ? OP_NONE : 3'(f % 6), pick_page(), pick_count());
      end
    end
    idle_start();

    while (grants_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== page_pool_allocator_top.f =====
+incdir+src
src/ppa_pkg.sv
src/ppa_ram.sv
src/ppa_queue.sv
src/ppa_front.sv
src/ppa_back.sv
src/page_pool_allocator_top.sv
tb/sv/tb_page_pool_allocator_top.sv
